FILE: src/gsfd_pkg.sv
// Shared types and constants for the gas sensor frame decoder.
package gsfd_pkg;

   localparam int unsigned FRAME_LEN = 13;
   localparam int unsigned GAS_CHANNELS = 4;

   localparam logic [3:0] POS_HUNT = 4'd0;
   localparam logic [3:0] POS_FIRST = 4'd1;
   localparam logic [3:0] POS_CHECK = 4'd14;

   localparam logic [15:0] FAULT_CODE = 16'hFF00;

   localparam logic [7:0] START_MARKER_RESET = 8'hFF;
   localparam logic [7:0] EXPECTED_COMMAND_RESET = 8'h86;
   localparam logic [15:0] TEMPERATURE_OFFSET_RESET = 16'd500;

   typedef enum logic [1:0] {
      CSR_START_MARKER = 2'd0,
      CSR_EXPECTED_COMMAND = 2'd1,
      CSR_TEMPERATURE_OFFSET = 2'd2,
      CSR_UNUSED = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_BAD_COMMAND = 2'd1,
      STATUS_BAD_CHECKSUM = 2'd2,
      STATUS_RESERVED = 2'd3
   } status_type;

   typedef struct packed {
      logic done;
      logic [7:0] check;
      logic [7:0] sum;
      logic [FRAME_LEN-1:0][7:0] data;
   } frame_type;

endpackage

FILE: src/gsfd_collect.sv
// Input register, frame position counter, running sum and frame byte shift line.
module gsfd_collect (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic [7:0] start_marker,
   input  logic advance,
   output gsfd_pkg::frame_type frame
);

   logic in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic [3:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [gsfd_pkg::FRAME_LEN-1:0][7:0] data_ff, data_in;
   logic fire;

   assign req_stall = in_valid_ff && !advance;
   assign fire = in_valid_ff && advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      data_in = data_ff;
      if (fire) begin
         if (pos_ff == gsfd_pkg::POS_HUNT) begin
            if (in_byte_ff == start_marker) begin
               pos_in = gsfd_pkg::POS_FIRST;
               sum_in = 8'd0;
            end
         end else if (pos_ff < gsfd_pkg::POS_CHECK) begin
            data_in = {in_byte_ff, data_ff[gsfd_pkg::FRAME_LEN-1:1]};
            sum_in = sum_ff + in_byte_ff;
            pos_in = pos_ff + 4'd1;
         end else begin
            pos_in = gsfd_pkg::POS_HUNT;
            sum_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff <= gsfd_pkg::POS_HUNT;
         sum_ff <= 8'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
      data_ff <= data_in;
   end

   assign frame.done = in_valid_ff && (pos_ff == gsfd_pkg::POS_CHECK);
   assign frame.check = in_byte_ff;
   assign frame.sum = sum_ff;
   assign frame.data = data_ff;

endmodule

FILE: src/gsfd_decode.sv
// Frame field decode, status check and result register.
module gsfd_decode (
   input  logic clock,
   input  logic reset,
   input  gsfd_pkg::frame_type frame,
   input  logic [7:0] expected_command,
   input  logic [15:0] temperature_offset,
   output logic advance,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_frame_status,
   output logic [15:0] rsp_gas_value_0,
   output logic [15:0] rsp_gas_value_1,
   output logic [15:0] rsp_gas_value_2,
   output logic [15:0] rsp_gas_value_3,
   output logic [3:0] rsp_gas_fault_mask,
   output logic signed [16:0] rsp_temperature_tenths,
   output logic [15:0] rsp_humidity_tenths
);

   logic valid_ff, valid_in;
   logic load;
   gsfd_pkg::status_type status_ff, status_in;
   logic [gsfd_pkg::GAS_CHANNELS-1:0][15:0] gas_ff, gas_in;
   logic [gsfd_pkg::GAS_CHANNELS-1:0] fault_ff, fault_in;
   logic signed [16:0] temp_ff, temp_in;
   logic [15:0] hum_ff, hum_in;
   logic [15:0] temp_raw;

   assign advance = !valid_ff || !rsp_stall;
   assign load = frame.done && advance;
   assign valid_in = advance ? frame.done : valid_ff;

   always_comb begin
      for (int i = 0; i < gsfd_pkg::GAS_CHANNELS; i++) begin
         gas_in[i] = {frame.data[1 + 2 * i], frame.data[2 + 2 * i]};
         fault_in[i] = (gas_in[i] == gsfd_pkg::FAULT_CODE);
      end
      temp_raw = {frame.data[9], frame.data[10]};
      temp_in = signed'({1'b0, temp_raw} - {1'b0, temperature_offset});
      hum_in = {frame.data[11], frame.data[12]};
      if (frame.data[0] != expected_command) begin
         status_in = gsfd_pkg::STATUS_BAD_COMMAND;
      end else if (8'(frame.sum + frame.check) != 8'd0) begin
         status_in = gsfd_pkg::STATUS_BAD_CHECKSUM;
      end else begin
         status_in = gsfd_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         gas_ff <= gas_in;
         fault_ff <= fault_in;
         temp_ff <= temp_in;
         hum_ff <= hum_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_gas_value_0 = gas_ff[0];
   assign rsp_gas_value_1 = gas_ff[1];
   assign rsp_gas_value_2 = gas_ff[2];
   assign rsp_gas_value_3 = gas_ff[3];
   assign rsp_gas_fault_mask = fault_ff;
   assign rsp_temperature_tenths = temp_ff;
   assign rsp_humidity_tenths = hum_ff;

endmodule

FILE: src/gas_sensor_frame_decoder_top.sv
// Top level of the gas sensor frame decoder: control registers and the two pipeline stages.
//
//   channel   direction   handshake           transaction
//   req       in          req_valid/stall     one received serial byte
//   rsp       out         rsp_valid/stall     one decoded frame
//   csr       in          csr_valid/ready     register index and write data
//
// One byte enters per cycle while req_stall is low; the checksum byte passes through
// the input register and then the result register on its way to its result.
// Reset clears the stage valids, the frame position and sum, and loads register defaults.
// A stalled result holds the input stage; req_stall rises only while both stages are full.
module gas_sensor_frame_decoder_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_rx_byte,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_frame_status,
   output logic [15:0] rsp_gas_value_0,
   output logic [15:0] rsp_gas_value_1,
   output logic [15:0] rsp_gas_value_2,
   output logic [15:0] rsp_gas_value_3,
   output logic [3:0] rsp_gas_fault_mask,
   output logic signed [16:0] rsp_temperature_tenths,
   output logic [15:0] rsp_humidity_tenths,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data
);

   logic [7:0] start_marker_ff;
   logic [7:0] expected_command_ff;
   logic [15:0] temperature_offset_ff;
   logic advance;
   gsfd_pkg::frame_type frame;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= gsfd_pkg::START_MARKER_RESET;
         expected_command_ff <= gsfd_pkg::EXPECTED_COMMAND_RESET;
         temperature_offset_ff <= gsfd_pkg::TEMPERATURE_OFFSET_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (gsfd_pkg::csr_index_type'(csr_index))
            gsfd_pkg::CSR_START_MARKER: start_marker_ff <= csr_data[7:0];
            gsfd_pkg::CSR_EXPECTED_COMMAND: expected_command_ff <= csr_data[7:0];
            gsfd_pkg::CSR_TEMPERATURE_OFFSET: temperature_offset_ff <= csr_data;
            default: ;
         endcase
      end
   end

   gsfd_collect u_collect (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .start_marker(start_marker_ff),
      .advance(advance),
      .frame(frame)
   );

   gsfd_decode u_decode (
      .clock(clock),
      .reset(reset),
      .frame(frame),
      .expected_command(expected_command_ff),
      .temperature_offset(temperature_offset_ff),
      .advance(advance),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_frame_status(rsp_frame_status),
      .rsp_gas_value_0(rsp_gas_value_0),
      .rsp_gas_value_1(rsp_gas_value_1),
      .rsp_gas_value_2(rsp_gas_value_2),
      .rsp_gas_value_3(rsp_gas_value_3),
      .rsp_gas_fault_mask(rsp_gas_fault_mask),
      .rsp_temperature_tenths(rsp_temperature_tenths),
      .rsp_humidity_tenths(rsp_humidity_tenths)
   );

   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> !req_stall)
      else $error("input stalled while result register empty");

   assert property (@(posedge clock) disable iff (reset)
      frame.done && !advance |=> frame.done && $stable(frame.check))
      else $error("blocked checksum byte lost");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gas_fault_mask[0] == (rsp_gas_value_0 == gsfd_pkg::FAULT_CODE))
         && (rsp_gas_fault_mask[3] == (rsp_gas_value_3 == gsfd_pkg::FAULT_CODE)))
      else $error("fault mask disagrees with gas value");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_status != gsfd_pkg::STATUS_RESERVED)
      else $error("reserved status code in result");

endmodule
